@@ sv/mts_pkg.sv @@
// Package with constants and types shared by the timer service files.
package mts_pkg;

  localparam int TimerCountDefault = 16;
  localparam logic [7:0] MaxCompare = 8'd230;
  localparam logic [7:0] CounterMargin = 8'd3;
  localparam logic [30:0] RepeatMin = 31'd2;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_HANDLE = 2'd2;
  localparam logic [1:0] KIND_DEQUEUE = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] timer_id;
    logic one_shot;
    logic kind_invalid;
    logic [30:0] interval;
    logic [7:0] counter_now;
    logic post_ok;
  } mts_in_t;

  typedef struct packed {
    logic accepted;
    logic [7:0] compare_value;
    logic handle_request;
    logic [4:0] fired_id;
    logic [4:0] expired_count;
    logic queue_overflow;
    logic [15:0] active_mask;
  } mts_out_t;

endpackage

@@ sv/mts_in_if.sv @@
// Valid/ready channel interface for input items.
interface mts_in_if import mts_pkg::*; ();
  logic valid;
  logic ready;
  mts_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/mts_out_if.sv @@
// Valid/ready channel interface for result items.
interface mts_out_if import mts_pkg::*; ();
  logic valid;
  logic ready;
  mts_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/mts_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input logic clk,
  input logic we,
  input logic [$clog2(Depth)-1:0] waddr,
  input logic [Width-1:0] wdata,
  input logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/multi_timer_service_unit.sv @@
// Multiplexed timer service: timer table in RAM, walked entry by entry (read, then update) on handle.
//
//   channel   dir  payload
//   req       in   kind, timer_id, one_shot, kind_invalid, interval, counter_now, post_ok
//   rsp       out  accepted, compare_value, handle_request, fired_id, expired_count, ...
//
// Start and match results are registered and valid in the cycle after the input transfer; a
// dequeue result passes through ST_DEQ and ST_HDONE, once the queue RAM read has returned.
// A handle result passes through ST_HREAD and ST_HMOD for each timer entry, then ST_HDONE:
// each entry is read, each active one updated and written back, with the compare minimum accumulated on the walk.
// Reset (rst, synchronous) clears the control state; the RAM contents are not cleared.
// A new item is taken only after the previous result has been transferred.
module multi_timer_service_unit import mts_pkg::*; #(
  parameter int TIMER_COUNT = TimerCountDefault
) (
  input logic clk,
  input logic rst,
  mts_in_if.sink req,
  mts_out_if.source rsp
);
  localparam int IdW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CntW = $clog2(TIMER_COUNT + 1);
  localparam int EntW = 1 + 32 + 32;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEQ = 3'd1;
  localparam logic [2:0] ST_HREAD = 3'd2;
  localparam logic [2:0] ST_HMOD = 3'd3;
  localparam logic [2:0] ST_HDONE = 3'd4;

  logic [2:0] state;
  mts_in_t item;
  logic [TIMER_COUNT-1:0] active_bits;
  logic [7:0] compare_reg;
  logic [15:0] outstanding_ticks;
  logic [IdW-1:0] queue_head, queue_tail;
  logic [CntW-1:0] queue_count;
  logic [IdW-1:0] idx;
  logic [15:0] ticks;
  logic [7:0] cand;
  logic [CntW-1:0] expired;
  logic overflow;
  logic deq_hit;
  logic out_valid;
  mts_out_t out_data;

  // Timer table: {one_shot, period, remaining}.
  logic t_we;
  logic [IdW-1:0] t_waddr, t_raddr;
  logic [EntW-1:0] t_wdata, t_rdata;
  mts_ram #(.Width(EntW), .Depth(TIMER_COUNT)) u_timer_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  logic q_we;
  logic [IdW-1:0] q_wdata, q_rdata;
  mts_ram #(.Width(IdW), .Depth(TIMER_COUNT)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(queue_tail), .wdata(q_wdata),
    .raddr(queue_head), .rdata(q_rdata)
  );

  logic accept;
  assign req.ready = (state == ST_IDLE) && !out_valid;
  assign accept = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  // Start item checks and values.
  logic start_ok;
  logic [31:0] start_sum;
  assign start_ok = ({24'd0, req.data.timer_id} < 32'(TIMER_COUNT))
                    && !req.data.kind_invalid
                    && !(!req.data.one_shot && req.data.interval <= RepeatMin);
  assign start_sum = {1'b0, req.data.interval} + {24'd0, req.data.counter_now};

  // Handle walk: per-entry update in ST_HMOD.
  logic e_one_shot;
  logic [31:0] e_period, e_rem, rem_sub, rem_new;
  logic e_active, e_expired, e_stop, e_push, q_full;
  assign e_one_shot = t_rdata[64];
  assign e_period = t_rdata[63:32];
  assign e_rem = t_rdata[31:0];
  assign e_active = active_bits[idx];
  assign rem_sub = e_rem - {16'd0, ticks};
  assign e_expired = $signed(rem_sub) <= 32'sd2;
  assign q_full = queue_count >= CntW'(TIMER_COUNT);
  always_comb begin
    rem_new = rem_sub;
    e_stop = 1'b0;
    e_push = 1'b0;
    if (e_expired) begin
      if (item.post_ok) begin
        if (!e_one_shot) begin
          rem_new = rem_sub + e_period;
        end else begin
          e_stop = 1'b1;
        end
        e_push = !q_full;
      end else begin
        rem_new = {24'd0, compare_reg};
      end
    end
  end

  logic cand_take;
  assign cand_take = $signed(rem_new) < $signed({24'd0, cand}) && !e_stop;

  logic [7:0] floor_val;
  assign floor_val = item.counter_now + CounterMargin;

  logic [TIMER_COUNT-1:0] id_bit;
  assign id_bit = TIMER_COUNT'(1) << req.data.timer_id[IdW-1:0];

  always_comb begin
    t_we = 1'b0;
    t_waddr = idx;
    t_wdata = {e_one_shot, e_period, rem_new};
    t_raddr = idx;
    q_we = 1'b0;
    q_wdata = idx;
    if (accept && req.data.kind == KIND_START && start_ok) begin
      t_we = 1'b1;
      t_waddr = req.data.timer_id[IdW-1:0];
      t_wdata = {req.data.one_shot, {1'b0, req.data.interval}, start_sum};
    end
    if (state == ST_HMOD && e_active) begin
      t_we = 1'b1;
      q_we = e_push && e_expired && item.post_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active_bits <= '0;
      compare_reg <= MaxCompare;
      outstanding_ticks <= '0;
      queue_head <= '0;
      queue_tail <= '0;
      queue_count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      deq_hit <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            item <= req.data;
            out_data.accepted <= 1'b0;
            out_data.handle_request <= 1'b0;
            out_data.fired_id <= 5'(TIMER_COUNT);
            out_data.expired_count <= '0;
            out_data.queue_overflow <= 1'b0;
            case (req.data.kind)
              KIND_START: begin
                if (start_ok) begin
                  active_bits <= active_bits | id_bit;
                  out_data.accepted <= 1'b1;
                  out_data.active_mask <= 16'(active_bits | id_bit);
                  if (start_sum < {24'd0, compare_reg}) begin
                    compare_reg <= start_sum[7:0];
                    out_data.compare_value <= start_sum[7:0];
                  end else begin
                    out_data.compare_value <= compare_reg;
                  end
                end else begin
                  out_data.active_mask <= 16'(active_bits);
                  out_data.compare_value <= compare_reg;
                end
                out_valid <= 1'b1;
              end
              KIND_MATCH: begin
                out_data.handle_request <= outstanding_ticks == 16'd0;
                outstanding_ticks <= outstanding_ticks + {8'd0, compare_reg} + 16'd1;
                out_data.compare_value <= compare_reg;
                out_data.active_mask <= 16'(active_bits);
                out_valid <= 1'b1;
              end
              KIND_HANDLE: begin
                ticks <= outstanding_ticks;
                outstanding_ticks <= '0;
                idx <= '0;
                cand <= MaxCompare;
                expired <= '0;
                overflow <= 1'b0;
                state <= ST_HREAD;
              end
              default: begin
                state <= ST_DEQ;
              end
            endcase
          end
        end
        ST_DEQ: begin
          // The head entry is read while the head pointer still points at it.
          state <= ST_HDONE;
          deq_hit <= queue_count != '0;
          if (queue_count != '0) begin
            queue_head <= (32'(queue_head) == TIMER_COUNT - 1) ? '0
                          : queue_head + IdW'(1);
            queue_count <= queue_count - CntW'(1);
          end
        end
        ST_HREAD: begin
          state <= ST_HMOD;
        end
        ST_HMOD: begin
          if (e_active) begin
            if (e_stop) begin
              active_bits[idx] <= 1'b0;
            end
            if (cand_take) begin
              cand <= rem_new[7:0];
            end
            if (e_expired && item.post_ok) begin
              if (q_full) begin
                overflow <= 1'b1;
              end else begin
                queue_tail <= (32'(queue_tail) == TIMER_COUNT - 1) ? '0
                              : queue_tail + IdW'(1);
                queue_count <= queue_count + CntW'(1);
                expired <= expired + CntW'(1);
              end
            end
          end
          if (32'(idx) == TIMER_COUNT - 1) begin
            state <= ST_HDONE;
          end else begin
            idx <= idx + IdW'(1);
            state <= ST_HREAD;
          end
        end
        ST_HDONE: begin
          state <= ST_IDLE;
          out_valid <= 1'b1;
          out_data.active_mask <= 16'(active_bits);
          if (item.kind == KIND_HANDLE) begin
            out_data.expired_count <= 5'(expired);
            out_data.queue_overflow <= overflow;
            if (active_bits == '0) begin
              compare_reg <= MaxCompare;
              out_data.compare_value <= MaxCompare;
            end else if (cand < floor_val) begin
              compare_reg <= floor_val;
              out_data.compare_value <= floor_val;
            end else begin
              compare_reg <= cand;
              out_data.compare_value <= cand;
            end
          end else begin
            out_data.compare_value <= compare_reg;
            if (deq_hit) begin
              out_data.fired_id <= 5'(q_rdata);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= CntW'(TIMER_COUNT))
    else $error("queue count above depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == ST_IDLE)
    else $error("ready outside idle");
  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HDONE) |=> rsp.valid)
    else $error("result missing after walk");
  a_no_write_idle_handle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HREAD) |-> !t_we)
    else $error("table write during read cycle");
`endif
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the multiplexed timer service unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;

  localparam int NTIMERS = 16;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst;

  mts_in_if req ();
  mts_out_if rsp ();

  multi_timer_service_unit #(.TIMER_COUNT(NTIMERS)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Predictor state.
  logic [15:0] run_bits;
  logic one_shot_tbl [NTIMERS];
  logic [31:0] period_tbl [NTIMERS];
  logic [31:0] remain_tbl [NTIMERS];
  logic [7:0] cmp_reg;
  logic [15:0] ticks_owed;
  logic [3:0] fired_fifo [NTIMERS];
  int fifo_head, fifo_tail, fifo_cnt;

  mts_in_t pending_items[$];
  mts_out_t expected_results[$];
  int send_idle_pct, recv_stall_pct;
  int errors, n_sent, n_checked, n_fired_seen, n_overflow_seen, quiet_cycles;
  bit hold_sender;
  bit in_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic mts_out_t predict_timer_step(mts_in_t it);
    mts_out_t r;
    logic [31:0] sum, owed;
    logic [7:0] cand, floor_v;
    r = '0;
    r.fired_id = 5'(NTIMERS);
    case (it.kind)
      KIND_START: begin
        if (it.timer_id < NTIMERS && !it.kind_invalid &&
            !(!it.one_shot && it.interval <= RepeatMin)) begin
          sum = {1'b0, it.interval} + 32'(it.counter_now);
          period_tbl[it.timer_id] = {1'b0, it.interval};
          one_shot_tbl[it.timer_id] = it.one_shot;
          remain_tbl[it.timer_id] = sum;
          run_bits[it.timer_id] = 1'b1;
          if (sum < 32'(cmp_reg)) cmp_reg = sum[7:0];
          r.accepted = 1'b1;
        end
      end
      KIND_MATCH: begin
        r.handle_request = (ticks_owed == 0);
        ticks_owed = ticks_owed + 16'(cmp_reg) + 16'd1;
      end
      KIND_HANDLE: begin
        owed = 32'(ticks_owed);
        ticks_owed = '0;
        for (int i = 0; i < NTIMERS; i++) begin
          if (!run_bits[i]) continue;
          remain_tbl[i] = remain_tbl[i] - owed;
          if ($signed(remain_tbl[i]) > 2) continue;
          if (it.post_ok) begin
            if (!one_shot_tbl[i]) remain_tbl[i] = remain_tbl[i] + period_tbl[i];
            else run_bits[i] = 1'b0;
            if (fifo_cnt >= NTIMERS) begin
              r.queue_overflow = 1'b1;
            end else begin
              fired_fifo[fifo_tail] = 4'(i);
              fifo_tail = (fifo_tail + 1) % NTIMERS;
              fifo_cnt++;
              r.expired_count = r.expired_count + 5'd1;
            end
          end else begin
            remain_tbl[i] = 32'(cmp_reg);
          end
        end
        if (run_bits == 0) begin
          cmp_reg = MaxCompare;
        end else begin
          cand = MaxCompare;
          for (int i = 0; i < NTIMERS; i++)
            if (run_bits[i] && $signed(remain_tbl[i]) < $signed({24'd0, cand}))
              cand = remain_tbl[i][7:0];
          floor_v = it.counter_now + CounterMargin;
          if (cand < floor_v) cand = floor_v;
          cmp_reg = cand;
        end
      end
      default: begin
        if (fifo_cnt != 0) begin
          r.fired_id = 5'(fired_fifo[fifo_head]);
          fifo_head = (fifo_head + 1) % NTIMERS;
          fifo_cnt--;
        end
      end
    endcase
    r.compare_value = cmp_reg;
    r.active_mask = run_bits;
    return r;
  endfunction

  function automatic mts_in_t make_item(logic [1:0] k, int id, bit os, int ivl, bit pok);
    mts_in_t it;
    it.kind = k;
    it.timer_id = 8'(id);
    it.one_shot = os;
    it.kind_invalid = 1'b0;
    it.interval = 31'(ivl);
    it.counter_now = 8'($urandom_range(0, 255));
    it.post_ok = pok;
    return it;
  endfunction

  // Driver: presents queued items, idling at random.
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || in_taken) begin
      if (!hold_sender && pending_items.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        req.valid <= 1'b1;
        req.data <= pending_items.pop_front();
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // A held item stays put; predict when the transfer happens.
  always @(posedge clk) begin
    in_taken <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      expected_results.push_back(predict_timer_step(req.data));
      n_sent++;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    mts_out_t exp_r;
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, rsp.data);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          n_checked++;
          if (rsp.data.fired_id != 5'(NTIMERS)) n_fired_seen++;
          if (rsp.data.queue_overflow) n_overflow_seen++;
          if (rsp.data !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, rsp.data);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || req.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(int count);
    mts_in_t it;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        // Mostly valid starts with small intervals so timers expire often.
        it = make_item(KIND_START, $urandom_range(0, NTIMERS - 1), $urandom_range(0, 1),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600), 1);
        if ($urandom_range(0, 9) == 0) it.timer_id = 8'($urandom);
        if ($urandom_range(0, 14) == 0) it.kind_invalid = 1'b1;
        if ($urandom_range(0, 9) == 0) it.interval = 31'($urandom_range(0, 2));
      end else begin
        it = make_item(sel < 60 ? KIND_MATCH : sel < 80 ? KIND_HANDLE : KIND_DEQUEUE,
                       $urandom, $urandom_range(0, 1), $urandom, $urandom_range(0, 5) != 0);
        it.kind_invalid = 1'($urandom_range(0, 1));
      end
      pending_items.push_back(it);
    end
  endtask

  initial begin
    mts_in_t it;
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    in_taken = 1'b0;
    run_bits = '0;
    cmp_reg = MaxCompare;
    ticks_owed = '0;
    fifo_head = 0; fifo_tail = 0; fifo_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_sender = 1'b0;
    errors = 0; n_sent = 0; n_checked = 0; n_fired_seen = 0; n_overflow_seen = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dequeue, rejected starts, extremes, expiry and overflow.
    pending_items.push_back(make_item(KIND_DEQUEUE, 0, 0, 0, 1));
    pending_items.push_back(make_item(KIND_START, 16, 1, 100, 1));
    pending_items.push_back(make_item(KIND_START, 255, 0, 100, 1));
    it = make_item(KIND_START, 3, 1, 100, 1); it.kind_invalid = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(make_item(KIND_START, 4, 0, 2, 1));
    pending_items.push_back(make_item(KIND_START, 4, 1, 0, 1));
    pending_items.push_back(make_item(KIND_START, 5, 0, 3, 1));
    pending_items.push_back(make_item(KIND_START, 0, 0, 32'h7fffffff, 1));
    pending_items.push_back(make_item(KIND_START, 15, 1, 7, 1));
    pending_items.push_back(make_item(KIND_MATCH, 0, 0, 0, 1));
    pending_items.push_back(make_item(KIND_MATCH, 0, 0, 0, 1));
    pending_items.push_back(make_item(KIND_HANDLE, 0, 0, 0, 0));
    pending_items.push_back(make_item(KIND_MATCH, 0, 0, 0, 1));
    pending_items.push_back(make_item(KIND_HANDLE, 0, 0, 0, 1));
    for (int i = 0; i < NTIMERS; i++)
      pending_items.push_back(make_item(KIND_START, i, 0, 3, 1));
    it = make_item(KIND_MATCH, 0, 0, 0, 1);
    pending_items.push_back(it);
    pending_items.push_back(make_item(KIND_HANDLE, 0, 0, 0, 1));
    pending_items.push_back(make_item(KIND_MATCH, 0, 0, 0, 1));
    pending_items.push_back(make_item(KIND_HANDLE, 0, 0, 0, 1));
    it = make_item(KIND_HANDLE, 0, 0, 0, 1); it.counter_now = 8'd255;
    pending_items.push_back(it);
    pending_items.push_back(make_item(KIND_DEQUEUE, 0, 0, 0, 1));
    wait_drained();

    // The sender pauses here while the random items are queued.
    hold_sender = 1'b1;
    queue_random(20);
    repeat (3) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 46 : 13) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 46 : 13) : 0;
      queue_random(170);
      wait_drained();
    end
    repeat (80) @(posedge clk);

    $display("Checked %0d results from %0d items; %0d fired ids popped, %0d overflows.",
             n_checked, n_sent, n_fired_seen, n_overflow_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
